// ===== hdl/spq_pkg.sv =====
package spq_pkg;

  localparam int unsigned Depth  = 16;
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam int unsigned PrioW  = 8;
  localparam int unsigned DataW  = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [DataW-1:0] data;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t item;
  } cmd_t;

endpackage

// ===== hdl/spq_in_if.sv =====
interface spq_in_if;
  logic                       valid;
  logic                       ready;
  spq_pkg::op_e               op;
  logic [spq_pkg::PrioW-1:0]  priority_req;
  logic [spq_pkg::DataW-1:0]  payload;

  modport source (output valid, op, priority_req, payload, input ready);
  modport sink (input valid, op, priority_req, payload, output ready);
endinterface

// ===== hdl/spq_out_if.sv =====
interface spq_out_if;
  logic                        valid;
  logic                        ready;
  spq_pkg::status_e            status;
  logic [spq_pkg::PrioW-1:0]   out_priority;
  logic [spq_pkg::DataW-1:0]   out_payload;
  logic [spq_pkg::CountW-1:0]  occupancy;

  modport source (output valid, status, out_priority, out_payload, occupancy, input ready);
  modport sink (input valid, status, out_priority, out_payload, occupancy, output ready);
endinterface

// ===== hdl/spq_cell.sv =====
module spq_cell (
  input  logic            clk_i,
  input  spq_pkg::cmd_t   cmd_i,
  input  logic            occ_i,
  input  spq_pkg::entry_t left_i,
  input  logic            left_keep_i,
  input  spq_pkg::entry_t right_i,
  output spq_pkg::entry_t entry_o,
  output logic            keep_o
);

  spq_pkg::entry_t entry_q, entry_d;

  // held entry stays in place on insert
  assign keep_o  = occ_i && (entry_q.prio >= cmd_i.item.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (!keep_o) begin
        entry_d = left_keep_i ? cmd_i.item : left_i;
      end
    end else if (cmd_i.rem) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// Bounded priority queue of spq_pkg::Depth entries kept sorted by descending
// priority in a row of cells, head in cell 0; equal priorities leave in
// arrival order. Each beat on in_i is an insert or a remove and yields
// exactly one beat on out_o with status, the removed entry (zero unless a
// successful remove) and the count after the operation. An insert into a
// full queue is dropped with status full; a remove from an empty queue gives
// status empty. All cells compare against the new priority and shift in
// parallel within each operation, and the result sits in an output register,
// so one beat per clock is taken while out_o.ready is high.
module sorted_priority_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  spq_in_if.sink       in_i,
  spq_out_if.source    out_o
);

  localparam int unsigned Depth  = spq_pkg::Depth;
  localparam int unsigned CountW = spq_pkg::CountW;

  logic [CountW-1:0]       count_q, count_d;
  logic                    out_valid_q;
  spq_pkg::status_e        status_q, status_d;
  spq_pkg::entry_t         res_q, res_d;

  logic                    accept;
  logic                    full, empty;
  spq_pkg::cmd_t           cmd;
  spq_pkg::entry_t         cell_entry [Depth];
  logic [Depth-1:0]        cell_keep;
  logic [Depth-1:0]        cell_occ;

  assign accept     = in_i.valid && in_i.ready;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign full       = (count_q == CountW'(Depth));
  assign empty      = (count_q == '0);

  always_comb begin
    cmd.item.prio = in_i.priority_req;
    cmd.item.data = in_i.payload;
    cmd.ins       = accept && (in_i.op == spq_pkg::OP_INSERT) && !full;
    cmd.rem       = accept && (in_i.op == spq_pkg::OP_REMOVE) && !empty;
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    spq_pkg::entry_t left, right;
    logic            left_keep;

    assign cell_occ[i] = (count_q > CountW'(i));

    if (i == 0) begin : g_head
      assign left      = cmd.item;
      assign left_keep = 1'b1;
    end else begin : g_body
      assign left      = cell_entry[i-1];
      assign left_keep = cell_keep[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign right = '0;
    end else begin : g_inner
      assign right = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .occ_i       (cell_occ[i]),
      .left_i      (left),
      .left_keep_i (left_keep),
      .right_i     (right),
      .entry_o     (cell_entry[i]),
      .keep_o      (cell_keep[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = spq_pkg::ST_OK;
    res_d    = '0;
    unique case (in_i.op)
      spq_pkg::OP_INSERT: begin
        if (full) begin
          status_d = spq_pkg::ST_FULL;
        end else begin
          count_d = count_q + CountW'(1);
        end
      end
      spq_pkg::OP_REMOVE: begin
        if (empty) begin
          status_d = spq_pkg::ST_EMPTY;
        end else begin
          count_d = count_q - CountW'(1);
          res_d   = cell_entry[0];
        end
      end
      default: begin
        status_d = spq_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      res_q    <= res_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = status_q;
  assign out_o.out_priority = res_q.prio;
  assign out_o.out_payload  = res_q.data;
  assign out_o.occupancy    = count_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(Depth))
    else $error("entry count above depth");

  a_full_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_i.op == spq_pkg::OP_INSERT) && full
    |=> out_o.valid && (out_o.status == spq_pkg::ST_FULL) && $stable(count_q))
    else $error("insert into full queue not dropped");

  a_remove_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_i.op == spq_pkg::OP_REMOVE) && !empty
    |=> (count_q == $past(count_q) - CountW'(1)) && (out_o.status == spq_pkg::ST_OK))
    else $error("remove did not shrink queue");

  for (genvar j = 1; j < Depth; j++) begin : g_chk
    a_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
      cell_occ[j] |-> (cell_entry[j-1].prio >= cell_entry[j].prio))
      else $error("cell row out of order");
  end

endmodule
